// ===== hw/rtl/sjtwt_pkg.sv =====
// Shared types, codes and key selection for the sorted job table.
// No dependencies; imported by sjtwt_cell and sorted_job_table_wait_times.
package sjtwt_pkg;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int KEY_W   = 16;
    localparam int WAIT_W  = 21;
    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    // Command carried in tuser of the input beat
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ENTRY = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // id in the lowest bits, then burst, then priority
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } t_job;

    // Job travelling down the row of cells
    typedef struct packed {
        logic vld;
        logic disp;  // a job has been displaced: every cell below shifts
        logic mode;  // key mode in force when the insert was accepted
        t_job job;
    } t_carry;

    function automatic logic [KEY_W-1:0] key_of(input logic mode, input t_job j);
        logic [KEY_W-1:0] k;
        k = mode ? j.burst : {{(KEY_W-PRIO_W){1'b0}}, j.prio};
        return k;
    endfunction

endpackage

// ===== hw/rtl/sjtwt_cell.sv =====
// One slot of the sorted job table: holds an entry and compares it with the
// job passing by, keeping or handing on. Depends on sjtwt_pkg.
module sjtwt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sjtwt_pkg::t_carry i_carry,
    output sjtwt_pkg::t_carry o_carry,
    output sjtwt_pkg::t_job   o_job
);
    import sjtwt_pkg::*;

    logic   r_valid, n_valid;
    t_job   r_job, n_job;
    t_carry r_carry, n_carry;
    logic   w_gt;

    assign w_gt = key_of(i_carry.mode, r_job) > key_of(i_carry.mode, i_carry.job);

    always_comb begin
        n_valid     = r_valid;
        n_job       = r_job;
        n_carry     = i_carry;
        n_carry.vld = 1'b0;
        if (i_carry.vld) begin
            if (!r_valid) begin
                // first free slot: settle here
                n_valid = 1'b1;
                n_job   = i_carry.job;
            end else if (i_carry.disp || w_gt) begin
                // take the passing job, push ours down
                n_job        = i_carry.job;
                n_carry.vld  = 1'b1;
                n_carry.disp = 1'b1;
                n_carry.job  = r_job;
            end else begin
                n_carry = i_carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_carry.vld <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_carry.vld <= n_carry.vld;
        end
        r_carry.disp <= n_carry.disp;
        r_carry.mode <= n_carry.mode;
        r_carry.job  <= n_carry.job;
        r_job        <= n_job;
    end

    assign o_carry = r_carry;
    assign o_job   = r_job;

endmodule

// ===== hw/rtl/sorted_job_table_wait_times.sv =====
// Sorted job table with waiting times: a row of TABLE_DEPTH compare-and-shift cells
// plus a readout stage. Depends on sjtwt_pkg and sjtwt_cell.
// Insert: status beat in the cycle after acceptance, one insert per cycle while the
//   output is free and no readout runs; the job then ripples one cell per cycle.
//   Readout: taken once the row has settled; then one entry per cycle while the
//   output is free. Sync active-low reset clears count, slot valids and key mode.
module sorted_job_table_wait_times #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,      // sort_key_mode
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // job_id[7:0], job_burst[23:8], job_priority[31:24]
    input  logic        i_s_axis_tuser,   // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // out_id[7:0], out_burst[23:8], out_priority[31:24],
                                          // out_wait[52:32], zero pad[55:53]
    output logic [1:0]  o_m_axis_tuser,   // status
    output logic        o_m_axis_tlast
);
    import sjtwt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic              r_mode;
    logic [CW-1:0]     r_count, n_count;
    logic              r_rd_active, n_rd_active;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [WAIT_W-1:0] r_wait, n_wait;

    logic              r_m_valid, n_m_valid;
    t_status           r_m_status, n_m_status;
    t_job              r_m_job, n_m_job;
    logic [WAIT_W-1:0] r_m_wait, n_m_wait;
    logic              r_m_last, n_m_last;

    t_carry            w_carry [TABLE_DEPTH+1];
    t_job              w_job [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_wave;

    logic              w_out_free, w_busy, w_full, w_acc, w_ins, w_rd, w_rd_last;
    logic [WAIT_W:0]   w_sum;
    t_job              w_rd_job;

    assign w_out_free = !r_m_valid || i_m_axis_tready;
    assign w_busy     = |w_wave;
    assign w_full     = (r_count == CW'(TABLE_DEPTH));
    assign o_s_axis_tready = w_out_free && !r_rd_active &&
                             (i_s_axis_tuser == CMD_INSERT || !w_busy);
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ins = w_acc && (i_s_axis_tuser == CMD_INSERT);
    assign w_rd  = w_acc && (i_s_axis_tuser == CMD_READ);

    // job entering the head cell
    always_comb begin
        w_carry[0].vld  = w_ins && !w_full;
        w_carry[0].disp = 1'b0;
        w_carry[0].mode = r_mode;
        w_carry[0].job  = t_job'(i_s_axis_tdata);
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        sjtwt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .o_job   (w_job[g])
        );
        assign w_wave[g] = w_carry[g+1].vld;
    end

    assign w_rd_job  = w_job[r_rd_idx];
    assign w_rd_last = (CW'(r_rd_idx) + CW'(1)) == r_count;
    assign w_sum     = {1'b0, r_wait} + (WAIT_W+1)'(w_rd_job.burst);

    always_comb begin
        n_count     = r_count;
        n_rd_active = r_rd_active;
        n_rd_idx    = r_rd_idx;
        n_wait      = r_wait;
        n_m_valid   = r_m_valid;
        n_m_status  = r_m_status;
        n_m_job     = r_m_job;
        n_m_wait    = r_m_wait;
        n_m_last    = r_m_last;
        priority if (w_ins) begin
            n_m_valid  = 1'b1;
            n_m_job    = '0;
            n_m_wait   = '0;
            n_m_last   = 1'b1;
            n_m_status = w_full ? ST_FULL : ST_OK;
            if (!w_full) begin
                n_count = r_count + CW'(1);
            end
        end else if (w_rd) begin
            if (r_count == '0) begin
                n_m_valid  = 1'b1;
                n_m_status = ST_EMPTY;
                n_m_job    = '0;
                n_m_wait   = '0;
                n_m_last   = 1'b1;
            end else begin
                n_m_valid   = !i_m_axis_tready && r_m_valid;
                n_rd_active = 1'b1;
                n_rd_idx    = '0;
                n_wait      = '0;
            end
        end else if (r_rd_active && w_out_free) begin
            n_m_valid  = 1'b1;
            n_m_status = ST_ENTRY;
            n_m_job    = w_rd_job;
            n_m_wait   = r_wait;
            n_m_last   = w_rd_last;
            // saturate the running sum
            n_wait     = (w_sum > (WAIT_W+1)'(WAIT_MAX)) ? WAIT_MAX : w_sum[WAIT_W-1:0];
            n_rd_idx   = r_rd_idx + IW'(1);
            if (w_rd_last) begin
                n_rd_active = 1'b0;
            end
        end else begin
            if (i_m_axis_tready) begin
                n_m_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_count     <= '0;
            r_rd_active <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_count     <= n_count;
            r_rd_active <= n_rd_active;
            r_m_valid   <= n_m_valid;
        end
        r_rd_idx   <= n_rd_idx;
        r_wait     <= n_wait;
        r_m_status <= n_m_status;
        r_m_job    <= n_m_job;
        r_m_wait   <= n_m_wait;
        r_m_last   <= n_m_last;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {3'b000, r_m_wait, r_m_job};
    assign o_m_axis_tuser  = r_m_status;
    assign o_m_axis_tlast  = r_m_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_rd_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_active |-> (CW'(r_rd_idx) < r_count))
        else $error("readout index beyond entry count");

    a_rd_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd |-> !w_busy)
        else $error("readout taken while a job is still moving down the row");

    a_ins_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins |=> (o_m_axis_tvalid && o_m_axis_tlast &&
                   (o_m_axis_tuser == ST_OK || o_m_axis_tuser == ST_FULL)))
        else $error("insert gave no status beat");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ins && w_full) |=> (r_count == $past(r_count)))
        else $error("dropped job changed the entry count");

endmodule

// ===== tb/job_table_checker.sv =====
// Scoreboard for the sorted job table: watches the config port and both stream
// channels, keeps its own copy of the table and compares every result beat.
// Depends on sjtwt_pkg.
module job_table_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // job_id[7:0], job_burst[23:8], job_priority[31:24]
    input  logic        i_s_tuser,    // command
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,    // out_id[7:0], out_burst[23:8], out_priority[31:24],
                                      // out_wait[52:32]
    input  logic [1:0]  i_m_tuser,    // status
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_pending
);
    import sjtwt_pkg::*;

    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     id;
        logic [BURST_W-1:0]  burst;
        logic [PRIO_W-1:0]   prio;
        logic [WAIT_W-1:0]   wait_sum;
        logic                last;
    } t_table_beat;

    t_job        held_jobs [TABLE_DEPTH];
    int          job_count;
    logic        key_mode;
    t_table_beat expected_beats [$];
    int          mismatches;
    int          beat_seq;

    assign o_mismatches = mismatches;

    initial begin
        job_count  = 0;
        key_mode   = 1'b0;
        mismatches = 0;
        beat_seq   = 0;
        o_pending  = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("result beat %0d %s: got %0d, expected %0d",
                                      beat_seq, name, got, want));
    endtask

    function automatic logic [KEY_W-1:0] job_key(input t_job j);
        logic [KEY_W-1:0] k;
        k = key_mode ? j.burst : {{(KEY_W-PRIO_W){1'b0}}, j.prio};
        return k;
    endfunction

    // Apply one accepted command to the table and queue the beats it produces
    task automatic predict_command(input logic cmd, input logic [31:0] data);
        t_job             job;
        int               slot;
        logic [KEY_W-1:0] new_key;
        logic [WAIT_W:0]  run_sum;
        t_table_beat      beat;
        job  = t_job'(data);
        beat = '0;
        beat.last = 1'b1;
        if (cmd == CMD_INSERT) begin
            if (job_count >= TABLE_DEPTH) begin
                beat.status = ST_FULL;
            end else begin
                new_key = job_key(job);
                slot = job_count;
                // lowest entry with a strictly greater key wins; equal keys stay ahead
                for (int i = job_count - 1; i >= 0; i--)
                    if (job_key(held_jobs[i]) > new_key)
                        slot = i;
                for (int i = job_count; i > slot; i--)
                    held_jobs[i] = held_jobs[i-1];
                held_jobs[slot] = job;
                job_count++;
                beat.status = ST_OK;
            end
            expected_beats.push_back(beat);
        end else if (job_count == 0) begin
            beat.status = ST_EMPTY;
            expected_beats.push_back(beat);
        end else begin
            run_sum = '0;
            for (int i = 0; i < job_count; i++) begin
                beat.status   = ST_ENTRY;
                beat.id       = held_jobs[i].id;
                beat.burst    = held_jobs[i].burst;
                beat.prio     = held_jobs[i].prio;
                beat.wait_sum = run_sum[WAIT_W-1:0];
                beat.last     = (i == job_count - 1);
                expected_beats.push_back(beat);
                run_sum += (WAIT_W+1)'(held_jobs[i].burst);
                if (run_sum > {1'b0, WAIT_MAX})
                    run_sum = {1'b0, WAIT_MAX};
            end
        end
    endtask

    task automatic check_result_beat();
        t_table_beat want;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat: status %0d tdata %h last %b",
                                      i_m_tuser, i_m_tdata, i_m_tlast));
            return;
        end
        want = expected_beats.pop_front();
        check_field("status",   64'(i_m_tuser),        64'(want.status));
        check_field("id",       64'(i_m_tdata[7:0]),   64'(want.id));
        check_field("burst",    64'(i_m_tdata[23:8]),  64'(want.burst));
        check_field("priority", 64'(i_m_tdata[31:24]), 64'(want.prio));
        check_field("wait",     64'(i_m_tdata[52:32]), 64'(want.wait_sum));
        check_field("last",     64'(i_m_tlast),        64'(want.last));
        beat_seq++;
    endtask

    // Results first: a beat leaving at this edge never stems from an item taken at it.
    // An insert taken at this edge still sorts by the key mode held before it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready)
                check_result_beat();
            if (i_s_tvalid && i_s_tready)
                predict_command(i_s_tuser, i_s_tdata);
            if (i_cfg_we)
                key_mode = i_cfg_wdata;
        end else begin
            job_count = 0;
            key_mode  = 1'b0;
            expected_beats.delete();
        end
        o_pending <= expected_beats.size();
    end

endmodule

// ===== tb/sorted_job_table_wait_times_tb.sv =====
// Top of the sorted job table testbench: clock, reset, config writes and job
// traffic with random idling. Depends on sjtwt_pkg, job_table_checker and the RTL.
module sorted_job_table_wait_times_tb;
    import sjtwt_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int CYCLE_LIMIT = 500_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int mismatch_count;
    int pending_results;
    int send_idle_pct;
    int stall_pct;
    int cycle_count;

    sorted_job_table_wait_times #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast)
    );

    job_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .o_mismatches(mismatch_count),
        .o_pending   (pending_results)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk)
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_job_table_wait_times verification failed");
            $finish;
        end
    end

    // Present one beat, with an optional idle gap first, and hold it until taken
    task automatic send_beat(input logic cmd, input t_job job);
        bit taken;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= job;
        s_tuser  <= cmd;
        do begin
            @(negedge i_clk);
            taken = s_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic send_insert(input logic [7:0] id, input logic [15:0] burst,
                               input logic [7:0] prio);
        t_job job;
        job.id    = id;
        job.burst = burst;
        job.prio  = prio;
        send_beat(CMD_INSERT, job);
    endtask

    task automatic send_readout();
        send_beat(CMD_READ, t_job'($urandom));
    endtask

    // Let every expected beat arrive, then let the insert ripple settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0)
            @(negedge i_clk);
        repeat (TABLE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_key_mode(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_items, input int gap_pct, input int stall);
        t_job job;
        logic cmd;
        send_idle_pct = gap_pct;
        stall_pct     = stall;
        repeat (n_items) begin
            cmd = ($urandom_range(99) < 30) ? CMD_READ : CMD_INSERT;
            job.id = ID_W'($urandom_range(255));
            // narrow ranges now and then so that equal keys turn up
            case ($urandom_range(3))
                0: job.burst = BURST_W'($urandom_range(7));
                1: job.burst = BURST_W'(16'hFFFF - $urandom_range(3));
                default: job.burst = BURST_W'($urandom_range(16'hFFFF));
            endcase
            job.prio = $urandom_range(1) ? PRIO_W'($urandom_range(255))
                                         : PRIO_W'($urandom_range(3));
            send_beat(cmd, job);
        end
        drain_results();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= CMD_INSERT;
        m_tready      <= 1'b1;
        cycle_count   <= 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // priority order: empty readout, field extremes, equal keys kept in arrival order
        write_key_mode(1'b0);
        send_readout();
        send_insert(8'h00, 16'h0000, 8'hFF);
        send_insert(8'hFF, 16'hFFFF, 8'h00);
        send_insert(8'h5A, 16'h1234, 8'h80);
        send_insert(8'hA5, 16'h0001, 8'h80);
        send_insert(8'h11, 16'h8000, 8'hFF);
        send_readout();
        drain_results();

        // burst order on a table left in priority order: no re-sort
        write_key_mode(1'b1);
        send_insert(8'h22, 16'h0100, 8'h01);
        send_insert(8'h33, 16'h0100, 8'h02);
        send_insert(8'h44, 16'hFFFF, 8'h10);
        send_insert(8'h55, 16'h0000, 8'h20);
        send_readout();
        drain_results();

        write_key_mode(1'b0);
        send_insert(8'h66, 16'h0042, 8'h7F);
        send_readout();
        drain_results();

        run_random_phase(90, 0, 0);
        write_key_mode(1'b1);
        run_random_phase(90, 53, 0);
        write_key_mode(1'b0);
        run_random_phase(90, 0, 53);
        write_key_mode(1'b1);
        run_random_phase(90, 24, 24);

        if (mismatch_count == 0 && pending_results == 0)
            $display("sorted_job_table_wait_times verification clean");
        else
            $display("sorted_job_table_wait_times verification failed");
        $finish;
    end

endmodule
